FILE: hdl/sida_pkg.sv
`default_nettype none

package sida_pkg;

  localparam int ValueWidth  = 32;
  localparam int CharWidth   = 7;
  localparam int Digits      = 10;
  localparam int DigitW      = 4;
  localparam int BcdWidth    = Digits * DigitW;
  localparam int DigitIdxW   = $clog2(Digits);

  // 4 stages x 8 shift steps cover all 32 magnitude bits
  localparam int DabbleSteps  = 8;
  localparam int DabbleStages = ValueWidth / DabbleSteps;

  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;
  localparam logic [CharWidth-1:0] CharZero  = 7'h30;

  typedef struct packed {
    logic                  sign;
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
  } work_t;

endpackage

`default_nettype wire

FILE: hdl/sida_negate.sv
`default_nettype none

module sida_negate (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [sida_pkg::ValueWidth-1:0] in_value,
  output logic                                in_ready,
  output logic                                out_valid,
  output sida_pkg::work_t                     out_data,
  input  wire logic                           out_ready
);
  import sida_pkg::*;

  logic valid;
  work_t data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // two's complement magnitude; the most negative value maps to 2^31 unsigned
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.sign <= in_value[ValueWidth-1];
      data.bcd  <= '0;
      data.bin  <= in_value[ValueWidth-1] ? (~in_value + 1'b1) : in_value;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sida_dabble.sv
`default_nettype none

module sida_dabble (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire sida_pkg::work_t in_data,
  output logic        in_ready,
  output logic        out_valid,
  output sida_pkg::work_t out_data,
  input  wire logic   out_ready
);
  import sida_pkg::*;

  logic  valid;
  work_t data;
  work_t w;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  // shift-add-3 steps for this slice of the magnitude
  always_comb begin
    w = in_data;
    for (int s = 0; s < DabbleSteps; s++) begin
      for (int d = 0; d < Digits; d++) begin
        if (w.bcd[d*DigitW +: DigitW] >= 4'd5) begin
          w.bcd[d*DigitW +: DigitW] = w.bcd[d*DigitW +: DigitW] + 4'd3;
        end
      end
      {w.bcd, w.bin} = {w.bcd[BcdWidth-2:0], w.bin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= w;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sida_serial.sv
`default_nettype none

module sida_serial (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire sida_pkg::work_t               in_data,
  output logic                               in_ready,
  output logic                               char_valid,
  output logic [sida_pkg::CharWidth-1:0]     character,
  output logic                               last,
  input  wire logic                          char_stall
);
  import sida_pkg::*;

  logic                busy;
  logic                sign_pend;
  logic [DigitIdxW-1:0] idx;
  logic [BcdWidth-1:0] bcd;

  logic [DigitW-1:0]    dig [Digits];
  logic [DigitIdxW-1:0] top_idx;
  logic                 fire;
  logic                 final_char;

  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      dig[i] = bcd[i*DigitW +: DigitW];
    end
  end

  // most significant nonzero digit; zero keeps a single digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < Digits; i++) begin
      if (in_data.bcd[i*DigitW +: DigitW] != '0) begin
        top_idx = DigitIdxW'(i);
      end
    end
  end

  assign final_char = !sign_pend && (idx == '0);
  assign char_valid = busy;
  assign last       = final_char;
  assign character  = sign_pend ? CharMinus : (CharZero + {3'b000, dig[idx]});
  assign fire       = busy && !char_stall;
  assign in_ready   = !busy || (fire && final_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      sign_pend <= 1'b0;
      idx       <= '0;
    end else if (in_ready && in_valid) begin
      busy      <= 1'b1;
      sign_pend <= in_data.sign;
      idx       <= top_idx;
    end else if (fire) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bcd <= in_data.bcd;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/signed_int_to_decimal_ascii_core.sv
`default_nettype none

// Channel     Ports                          Transaction
// ---------   ----------------------------   --------------------------------
// value in    value, value_valid, value_stall  one signed 32-bit value
// char out    character, last, char_valid,   one ASCII char; last marks the
//             char_stall                      final char of a value's text
//
// Path from value transaction to first char, each step registered: negate,
// four double-dabble stages of 8 shift steps each, serializer load.
// Each value gives 1 to 11 chars on the output port: one char per cycle while
// char_stall is low, set by the serializer; the pipeline ahead of it accepts
// a value every cycle until it fills behind a serializer that is still busy.
// rst is synchronous and clears every stage valid and the serializer.
// char_stall holds the current char; backpressure ripples up to value_stall.
module signed_int_to_decimal_ascii_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [sida_pkg::ValueWidth-1:0] value,
  input  wire logic                           value_valid,
  output logic                                value_stall,
  output logic [sida_pkg::CharWidth-1:0]      character,
  output logic                                last,
  output logic                                char_valid,
  input  wire logic                           char_stall
);
  import sida_pkg::*;

  // stage chain: index 0 is the negate stage output, DabbleStages the last dabble
  logic  st_valid [DabbleStages+1];
  logic  st_ready [DabbleStages+1];
  work_t st_data  [DabbleStages+1];
  logic  neg_in_ready;

  assign value_stall = !neg_in_ready;

  sida_negate u_negate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (value_valid),
    .in_value  (value),
    .in_ready  (neg_in_ready),
    .out_valid (st_valid[0]),
    .out_data  (st_data[0]),
    .out_ready (st_ready[0])
  );

  // binary to BCD, 8 bits of magnitude per stage
  for (genvar g = 0; g < DabbleStages; g++) begin : g_dabble
    sida_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[g]),
      .in_data   (st_data[g]),
      .in_ready  (st_ready[g]),
      .out_valid (st_valid[g+1]),
      .out_data  (st_data[g+1]),
      .out_ready (st_ready[g+1])
    );
  end

  // digits out most significant first, minus sign ahead of them
  sida_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid[DabbleStages]),
    .in_data    (st_data[DabbleStages]),
    .in_ready   (st_ready[DabbleStages]),
    .char_valid (char_valid),
    .character  (character),
    .last       (last),
    .char_stall (char_stall)
  );

  // only '-' or a decimal digit ever leaves the block
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (character == CharMinus) ||
                   ((character >= CharZero) && (character <= CharZero + 7'd9)))
    else $error("illegal character on output");

  // a minus sign never ends a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && character == CharMinus) |-> !last)
    else $error("minus sign flagged as last");

  // after a minus sign transaction a digit follows
  a_digit_after_minus: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && character == CharMinus) |=>
      (char_valid && character != CharMinus))
    else $error("no digit after minus sign");

  // input backpressure only when the first stage holds a value
  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    value_stall |-> st_valid[0])
    else $error("input stalled with empty first stage");

endmodule

`default_nettype wire
